>>> hw/rtl/stli_pkg.sv
package stli_pkg;

   localparam int DEPTH     = 64;
   localparam int FRAC_BITS = 16;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int CNT_W     = $clog2(DEPTH + 1);
   localparam int DIFF_W    = 33;
   localparam int FRAC_W    = FRAC_BITS + 1;
   localparam int PROD_W    = DIFF_W + FRAC_W;
   localparam int STEP_W    = $clog2(FRAC_BITS + 1);

   localparam logic [1:0] KIND_CLEAR  = 2'd0;
   localparam logic [1:0] KIND_APPEND = 2'd1;
   localparam logic [1:0] KIND_QUERY  = 2'd2;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_NOT_LOADED = 2'd1;
   localparam logic [1:0] STATUS_FULL       = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] altitude;
      logic signed [31:0] temperature;
      logic signed [31:0] pressure;
      logic signed [31:0] density;
      logic signed [31:0] sound_speed;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] result_altitude;
      logic signed [31:0] result_temperature;
      logic signed [31:0] result_pressure;
      logic signed [31:0] result_density;
      logic signed [31:0] result_sound_speed;
   } rsp_type;

   typedef logic [3:0][31:0] vals_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SRCH,
      ST_SWAIT,
      ST_RDA,
      ST_RDB,
      ST_PREP,
      ST_DIV,
      ST_MUL,
      ST_ADD,
      ST_EMIT
   } state_type;

endpackage

>>> hw/rtl/stli_table.sv
module stli_table
   import stli_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_key,
   input  vals_type          wr_vals,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_key,
   output vals_type          rd_vals
);

   logic [31:0] key_mem [DEPTH];
   vals_type    val_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_key;
         val_mem[wr_addr] <= wr_vals;
      end
      rd_key  <= key_mem[rd_addr];
      rd_vals <= val_mem[rd_addr];
   end

endmodule

>>> hw/rtl/stli_frac_div.sv
module stli_frac_div
   import stli_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIFF_W-1:0]     num,
   input  logic [DIFF_W-1:0]     den,
   output logic                  done,
   output logic [FRAC_BITS-1:0]  quot
);

   logic [DIFF_W:0]        rem_ff, rem_in;
   logic [DIFF_W-1:0]      den_ff, den_in;
   logic [FRAC_BITS-1:0]   quot_ff, quot_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   busy_ff, busy_in;
   logic [DIFF_W:0]        shifted;

   always_comb begin
      shifted = {rem_ff[DIFF_W-1:0], 1'b0};
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = {1'b0, num};
         den_in  = den;
         step_in = STEP_W'(FRAC_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in  = shifted - {1'b0, den_ff};
            quot_in = {quot_ff[FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in  = shifted;
            quot_in = {quot_ff[FRAC_BITS-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         busy_in = (step_ff != STEP_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = busy_ff && (step_ff == STEP_W'(1));
   assign quot = quot_in;

endmodule

>>> hw/rtl/sorted_table_linear_interpolator.sv
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_data  (req_type)
// rsp       out        rsp_valid/rsp_stall  rsp_data  (rsp_type)
//
// clear, append and unused kinds answer in the cycle after the request is taken
// a query reads the end keys (answering from there when clamped), takes the search steps
// (up to 7 steps at 64 rows), fetches the bracketing rows, runs the divider (skipped when
// the fraction is zero or one), does the four multiply/add steps and loads the result
// reset (synchronous) empties the table; the stores themselves are not cleared
// a result held under rsp_stall stalls the next request; rsp_valid never waits on rsp_stall
module sorted_table_linear_interpolator
   import stli_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CNT_W-1:0]  lo_ff, lo_in, hi_ff, hi_in;
   logic [CNT_W-1:0]  mid_ff, mid_in, b_ff, b_in;
   logic [31:0]       q_ff, q_in, ka_ff, ka_in, kb_ff, kb_in;
   vals_type          va_ff, va_in, vb_ff, vb_in, res_ff, res_in;
   logic [31:0]       res_alt_ff, res_alt_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [1:0]        idx_ff, idx_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              accept, out_free;
   logic              wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [31:0]       rd_key;
   vals_type          rd_vals, wr_vals;
   logic              div_start, div_done;
   logic [FRAC_BITS-1:0] div_quot;
   logic signed [DIFF_W-1:0] num, den, diff;
   logic [CNT_W-1:0]  last, mid_calc, b_calc;
   logic [CNT_W:0]    mid_sum;
   logic signed [PROD_W-1:0] prod_adj;
   logic signed [31:0] part;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;
   assign last      = cnt_ff - CNT_W'(1);
   assign mid_sum   = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mid_calc  = mid_sum[CNT_W:1];
   assign wr_vals   = {req_data.temperature, req_data.pressure,
                       req_data.density, req_data.sound_speed};
   assign num  = DIFF_W'($signed(q_ff)) - DIFF_W'($signed(ka_ff));
   assign den  = DIFF_W'($signed(kb_ff)) - DIFF_W'($signed(ka_ff));
   assign diff = DIFF_W'($signed(vb_ff[idx_ff])) - DIFF_W'($signed(va_ff[idx_ff]));
   assign prod_adj = prod_ff + (prod_ff[PROD_W-1] ?
                     PROD_W'((64'd1 << FRAC_BITS) - 64'd1) : PROD_W'(0));
   assign part = 32'(prod_adj >>> FRAC_BITS);

   always_comb begin
      if (lo_ff == '0) begin
         b_calc = CNT_W'(1);
      end else if (lo_ff > last) begin
         b_calc = last;
      end else begin
         b_calc = lo_ff;
      end
   end

   stli_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_key  (req_data.altitude),
      .wr_vals (wr_vals),
      .rd_addr (rd_addr),
      .rd_key  (rd_key),
      .rd_vals (rd_vals)
   );

   stli_frac_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num),
      .den   (den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_data.kind == KIND_QUERY && cnt_ff != '0) begin
               state_in = ST_FIRST;
            end
         end
         ST_FIRST: begin
            state_in = ($signed(q_ff) <= $signed(rd_key)) ? ST_EMIT : ST_LAST;
         end
         ST_LAST: begin
            state_in = ($signed(q_ff) >= $signed(rd_key)) ? ST_EMIT : ST_SRCH;
         end
         ST_SRCH:  state_in = (lo_ff < hi_ff) ? ST_SWAIT : ST_RDA;
         ST_SWAIT: state_in = ST_SRCH;
         ST_RDA:   state_in = ST_RDB;
         ST_RDB:   state_in = ST_PREP;
         ST_PREP: begin
            state_in = (den <= 0 || num <= 0 || num >= den) ? ST_MUL : ST_DIV;
         end
         ST_DIV:   state_in = div_done ? ST_MUL : ST_DIV;
         ST_MUL:   state_in = ST_ADD;
         ST_ADD:   state_in = (idx_ff == 2'd3) ? ST_EMIT : ST_MUL;
         ST_EMIT:  state_in = out_free ? ST_IDLE : ST_EMIT;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      cnt_in       = cnt_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      b_in         = b_ff;
      q_in         = q_ff;
      ka_in        = ka_ff;
      kb_in        = kb_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      res_in       = res_ff;
      res_alt_in   = res_alt_ff;
      frac_in      = frac_ff;
      idx_in       = idx_ff;
      prod_in      = prod_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      rd_addr      = '0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               q_in         = req_data.altitude;
               rsp_in       = '0;
               rsp_valid_in = 1'b1;
               priority if (req_data.kind == KIND_CLEAR) begin
                  cnt_in = '0;
               end else if (req_data.kind == KIND_APPEND) begin
                  if (cnt_ff < CNT_W'(DEPTH)) begin
                     wr_en  = 1'b1;
                     cnt_in = cnt_ff + CNT_W'(1);
                  end else begin
                     rsp_in.status = STATUS_FULL;
                  end
               end else if (req_data.kind == KIND_QUERY) begin
                  if (cnt_ff == '0) begin
                     rsp_in.status = STATUS_NOT_LOADED;
                  end else begin
                     rsp_valid_in = rsp_valid_ff && rsp_stall;
                  end
               end else begin
                  rsp_in = '0;
               end
            end
         end
         ST_FIRST: begin
            res_in     = rd_vals;
            res_alt_in = rd_key;
            rd_addr    = last[ADDR_W-1:0];
         end
         ST_LAST: begin
            res_in     = rd_vals;
            res_alt_in = rd_key;
            lo_in      = '0;
            hi_in      = cnt_ff;
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               rd_addr = mid_calc[ADDR_W-1:0];
               mid_in  = mid_calc;
            end else begin
               b_in    = b_calc;
               rd_addr = ADDR_W'(b_calc - CNT_W'(1));
            end
         end
         ST_SWAIT: begin
            if ($signed(rd_key) < $signed(q_ff)) begin
               lo_in = mid_ff + CNT_W'(1);
            end else begin
               hi_in = mid_ff;
            end
         end
         ST_RDA: begin
            ka_in   = rd_key;
            va_in   = rd_vals;
            rd_addr = b_ff[ADDR_W-1:0];
         end
         ST_RDB: begin
            kb_in = rd_key;
            vb_in = rd_vals;
         end
         ST_PREP: begin
            idx_in     = '0;
            res_alt_in = q_ff;
            if (den <= 0 || num <= 0) begin
               frac_in = '0;
            end else if (num >= den) begin
               frac_in = FRAC_W'(1) << FRAC_BITS;
            end else begin
               div_start = 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               frac_in = {1'b0, div_quot};
            end
         end
         ST_MUL: begin
            prod_in = PROD_W'(diff) * $signed({{(PROD_W-FRAC_W){1'b0}}, frac_ff});
         end
         ST_ADD: begin
            res_in[idx_ff] = va_ff[idx_ff] + part;
            idx_in         = idx_ff + 2'd1;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_in.status             = STATUS_OK;
               rsp_in.result_altitude    = res_alt_ff;
               rsp_in.result_temperature = res_ff[3];
               rsp_in.result_pressure    = res_ff[2];
               rsp_in.result_density     = res_ff[1];
               rsp_in.result_sound_speed = res_ff[0];
               rsp_valid_in              = 1'b1;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff && rsp_stall;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff      <= lo_in;
      hi_ff      <= hi_in;
      mid_ff     <= mid_in;
      b_ff       <= b_in;
      q_ff       <= q_in;
      ka_ff      <= ka_in;
      kb_ff      <= kb_in;
      va_ff      <= va_in;
      vb_ff      <= vb_in;
      res_ff     <= res_in;
      res_alt_ff <= res_alt_in;
      frac_ff    <= frac_in;
      idx_ff     <= idx_in;
      prod_ff    <= prod_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> bench/sorted_table_linear_interpolator_tb.sv
`timescale 1ns / 1ps

module sorted_table_linear_interpolator_tb;
   import stli_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   sorted_table_linear_interpolator i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // shadow table
   int unsigned    rows;
   logic signed [31:0] keys [DEPTH];
   logic signed [31:0] temps [DEPTH];
   logic signed [31:0] press [DEPTH];
   logic signed [31:0] dens [DEPTH];
   logic signed [31:0] sounds [DEPTH];

   rsp_type expected_rsps [$];
   int      mismatches = 0;
   int      unexpected = 0;
   int      cycles = 0;
   int      n_queries = 0;
   int      n_interp = 0;
   bit      hold_long = 1'b0;
   bit      stall_free = 1'b0;

   function automatic logic signed [31:0] blend(logic signed [31:0] lo,
                                                logic signed [31:0] hi,
                                                longint frac);
      longint diff;
      longint part;
      diff = longint'(hi) - longint'(lo);
      part = (diff * frac) / (longint'(1) << FRAC_BITS);
      return 32'(longint'(lo) + part);
   endfunction

   function automatic rsp_type interpolate_table(req_type r);
      rsp_type o;
      int unsigned last, lo, hi, mid, a, b;
      longint num, den, frac;
      o = '0;
      case (r.kind)
         KIND_CLEAR: rows = 0;
         KIND_APPEND: begin
            if (rows < DEPTH) begin
               keys[rows] = r.altitude;
               temps[rows] = r.temperature;
               press[rows] = r.pressure;
               dens[rows] = r.density;
               sounds[rows] = r.sound_speed;
               rows++;
            end else begin
               o.status = STATUS_FULL;
            end
         end
         KIND_QUERY: begin
            n_queries++;
            if (rows == 0) begin
               o.status = STATUS_NOT_LOADED;
               return o;
            end
            last = rows - 1;
            if (r.altitude <= keys[0]) begin
               b = 0;
               o.result_altitude = keys[0];
            end else if (r.altitude >= keys[last]) begin
               b = last;
               o.result_altitude = keys[last];
            end else begin
               n_interp++;
               lo = 0;
               hi = rows;
               while (lo < hi) begin
                  mid = (lo + hi) >> 1;
                  if (keys[mid] < r.altitude) lo = mid + 1;
                  else hi = mid;
               end
               b = lo;
               if (b < 1) b = 1;
               if (b > last) b = last;
               a = b - 1;
               num = longint'(r.altitude) - longint'(keys[a]);
               den = longint'(keys[b]) - longint'(keys[a]);
               if (den <= 0 || num <= 0) frac = 0;
               else if (num >= den) frac = longint'(1) << FRAC_BITS;
               else frac = (num * (longint'(1) << FRAC_BITS)) / den;
               o.result_altitude = r.altitude;
               o.result_temperature = blend(temps[a], temps[b], frac);
               o.result_pressure = blend(press[a], press[b], frac);
               o.result_density = blend(dens[a], dens[b], frac);
               o.result_sound_speed = blend(sounds[a], sounds[b], frac);
               return o;
            end
            o.result_temperature = temps[b];
            o.result_pressure = press[b];
            o.result_density = dens[b];
            o.result_sound_speed = sounds[b];
         end
         default: ;
      endcase
      return o;
   endfunction

   // response checking
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         cycles <= cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               unexpected++;
               if (unexpected + mismatches <= 10)
                  $display("unexpected response %h", rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.status !== want.status ||
                   rsp_data.result_altitude !== want.result_altitude ||
                   rsp_data.result_temperature !== want.result_temperature ||
                   rsp_data.result_pressure !== want.result_pressure ||
                   rsp_data.result_density !== want.result_density ||
                   rsp_data.result_sound_speed !== want.result_sound_speed) begin
                  mismatches++;
                  if (mismatches + unexpected <= 10)
                     $display("mismatch: expected %h actual %h", want, rsp_data);
               end
            end
         end
      end
   end

   // receiver stall pattern
   always @(negedge clock) begin
      int unsigned k;
      if (hold_long) begin
         rsp_stall <= 1'b1;
         for (k = 0; k < 300; k++) @(negedge clock);
         hold_long = 1'b0;
         rsp_stall <= 1'b0;
      end else if (stall_free) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("sorted_table_linear_interpolator verification failed");
         $finish;
      end
   end

   task automatic send(req_type r, bit check_fixed, rsp_type fixed_rsp);
      rsp_type p;
      req_data <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      p = interpolate_table(r);
      if (check_fixed && p !== fixed_rsp) begin
         mismatches++;
         if (mismatches + unexpected <= 10)
            $display("directed row: table expected %h predictor %h", fixed_rsp, p);
      end
      expected_rsps.insert(expected_rsps.size(), check_fixed ? fixed_rsp : p);
      @(negedge clock);
   endtask

   task automatic pause_sender();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
   endtask

   function automatic req_type mk(logic [1:0] kind, logic signed [31:0] alt,
                                  logic signed [31:0] v);
      req_type r;
      r.kind = kind;
      r.altitude = alt;
      r.temperature = v;
      r.pressure = ~v;
      r.density = v ^ 32'h5a5a_5a5a;
      r.sound_speed = -v;
      return r;
   endfunction

   function automatic req_type random_row(logic signed [31:0] alt);
      req_type r;
      r.kind = KIND_APPEND;
      r.altitude = alt;
      r.temperature = $urandom;
      r.pressure = $urandom;
      r.density = $urandom;
      r.sound_speed = $urandom;
      return r;
   endfunction

   typedef struct {
      req_type stim;
      bit      fixed;
      rsp_type want;
   } vector_type;

   vector_type directed [$];

   function automatic rsp_type rsp(logic [1:0] st, logic signed [31:0] alt,
                                   logic signed [31:0] v);
      rsp_type o;
      o.status = st;
      o.result_altitude = alt;
      o.result_temperature = v;
      o.result_pressure = ~v;
      o.result_density = v ^ 32'h5a5a_5a5a;
      o.result_sound_speed = -v;
      return o;
   endfunction

   function automatic rsp_type status_only(logic [1:0] st);
      rsp_type o;
      o = '0;
      o.status = st;
      return o;
   endfunction

   function automatic void add(req_type s, bit f, rsp_type w);
      vector_type e;
      e.stim = s;
      e.fixed = f;
      e.want = w;
      directed.insert(directed.size(), e);
   endfunction

   initial begin
      int unsigned i, j, n, total, burst;
      logic signed [31:0] k, step, alt;
      req_type r;

      rows = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      add(mk(KIND_QUERY, 32'sh7fff_ffff, 0), 1, status_only(STATUS_NOT_LOADED));
      add(mk(KIND_UNUSED, -1, -1), 1, '0);
      add(mk(KIND_APPEND, 32'sh8000_0000, 32'sh7fff_ffff), 1, '0);
      add(mk(KIND_APPEND, 0, 32'sh8000_0000), 1, '0);
      add(mk(KIND_APPEND, 32'sh7fff_ffff, 100), 1, '0);
      add(mk(KIND_QUERY, 32'sh8000_0000, 0), 1,
          rsp(STATUS_OK, 32'sh8000_0000, 32'sh7fff_ffff));
      add(mk(KIND_QUERY, 32'sh7fff_ffff, 0), 1, rsp(STATUS_OK, 32'sh7fff_ffff, 100));
      add(mk(KIND_QUERY, 0, 0), 0, '0);
      add(mk(KIND_QUERY, -1, 0), 0, '0);
      add(mk(KIND_QUERY, 1, 0), 0, '0);
      add(mk(KIND_QUERY, 32'sh4000_0000, 0), 0, '0);
      add(mk(KIND_CLEAR, 5, 5), 1, '0);
      add(mk(KIND_QUERY, 5, 0), 1, status_only(STATUS_NOT_LOADED));
      // non-ascending keys and a single row
      add(mk(KIND_APPEND, 50, 7), 1, '0);
      add(mk(KIND_QUERY, 60, 0), 1, rsp(STATUS_OK, 50, 7));
      add(mk(KIND_APPEND, 200, 9), 1, '0);
      add(mk(KIND_APPEND, 100, 11), 1, '0);
      add(mk(KIND_APPEND, 300, 13), 1, '0);
      add(mk(KIND_QUERY, 150, 0), 0, '0);
      add(mk(KIND_QUERY, 250, 0), 0, '0);
      add(mk(KIND_QUERY, 100, 0), 0, '0);
      foreach (directed[d]) send(directed[d].stim, directed[d].fixed, directed[d].want);

      // fill past depth
      send(mk(KIND_CLEAR, 0, 0), 1, '0);
      for (i = 0; i < DEPTH + 2; i++)
         send(random_row(32'(i * 1000 - 30000)), 0, '0);
      send(mk(KIND_QUERY, 32'sd2500, 0), 0, '0);

      // long receiver hold while offering back-to-back requests
      hold_long = 1'b1;
      for (i = 0; i < 20; i++) send(mk(KIND_QUERY, $urandom_range(0, 60000) - 30000, 0), 0, '0);
      drain();

      total = 0;
      while (total < 700) begin
         if ($urandom_range(0, 9) == 0) begin
            drain();
            stall_free = $urandom_range(0, 1);
         end
         n = $urandom_range(1, 12);
         if ($urandom_range(0, 3) == 0) n = $urandom_range(30, DEPTH + 3);
         send(mk(KIND_CLEAR, $urandom, $urandom), 0, '0);
         k = $urandom_range(0, 3) == 0 ? $urandom : -$signed(32'($urandom_range(0, 1 << 20)));
         for (j = 0; j < n; j++) begin
            step = $urandom_range(0, 7) == 0 ? -$signed(32'($urandom_range(0, 50)))
                                           : 32'($urandom_range(0, 1 << ($urandom_range(0, 24))));
            k = k + step;
            send(random_row(k), 0, '0);
            total++;
         end
         burst = $urandom_range(4, 30);
         for (j = 0; j < burst; j++) begin
            case ($urandom_range(0, 19))
               0: r = mk(KIND_UNUSED, $urandom, $urandom);
               1: r = random_row($urandom);
               2: r = mk(KIND_QUERY, $urandom, $urandom);
               3: r = mk(KIND_QUERY, k, 0);
               default: begin
                  alt = (n > 0) ? keys[$urandom_range(0, rows > 0 ? rows - 1 : 0)] : 0;
                  r = mk(KIND_QUERY, alt + $signed(32'($urandom_range(0, 1 << 16))) - 32'sd32768,
                         $urandom);
               end
            endcase
            send(r, 0, '0);
            total++;
            if ($urandom_range(0, 4) == 0) pause_sender();
         end
      end

      stall_free = 1'b0;
      drain();
      repeat (100) @(negedge clock);
      $display("covered %0d queries, %0d interpolated, with full-table drops and long stalls",
               n_queries, n_interp);
      if (mismatches == 0 && unexpected == 0 && expected_rsps.size() == 0) begin
         $display("sorted_table_linear_interpolator verification clean");
      end else begin
         $display("%0d mismatches, %0d unexpected, %0d missing", mismatches, unexpected,
                  expected_rsps.size());
         $display("sorted_table_linear_interpolator verification failed");
      end
      $finish;
   end

endmodule
